/* rtl/core/chbd_pkg.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared constants, token types and the byte classifier used by the front
// and back parts of the decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  localparam int SIZE_BITS = 48;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // Result classes of a byte.
  localparam logic [1:0] CLS_FRAME   = 2'd0;
  localparam logic [1:0] CLS_PAYLOAD = 2'd1;
  localparam logic [1:0] CLS_TRAILER = 2'd2;

  typedef enum logic [2:0] {
    TK_LF,
    TK_CR,
    TK_SEMI,
    TK_WS,
    TK_HEX,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] data;
    tok_kind_t  kind;
    logic [3:0] hex;
  } tok_t;

  typedef struct packed {
    logic [1:0] byte_class;
    logic [7:0] out_byte;
    logic       body_done;
    logic       format_error;
    logic       over_limit;
  } res_t;

  function automatic tok_t classify(input logic [7:0] c);
    tok_t t;
    t.data = c;
    t.kind = TK_OTHER;
    t.hex  = 4'd0;
    if (c == CHAR_LF) begin
      t.kind = TK_LF;
    end else if (c == CHAR_CR) begin
      t.kind = TK_CR;
    end else if (c == CHAR_SEMI) begin
      t.kind = TK_SEMI;
    end else if (c == CHAR_SP || c == CHAR_TAB) begin
      t.kind = TK_WS;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t.kind = TK_HEX;
      t.hex  = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t.kind = TK_HEX;
      t.hex  = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t.kind = TK_HEX;
      t.hex  = 4'(c - 8'h37);
    end
    return t;
  endfunction

endpackage

/* rtl/core/chbd_front.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder front end
// Accepts raw bytes, classifies each one and holds the tokens in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module chbd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_data_byte,
  output logic              tok_valid,
  output chbd_pkg::tok_t    tok,
  input  logic              tok_take
);

  chbd_pkg::tok_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           pop;

  assign in_full   = (cnt_r == 2'd2);
  assign tok_valid = (cnt_r != 2'd0);
  assign tok       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = tok_take && tok_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= chbd_pkg::classify(in_data_byte);
    end
  end

endmodule

/* rtl/core/chbd_back.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder back end
// Runs the framing state machine on classified tokens, one per cycle, and
// queues the results in a two-entry output queue, stalling while it is full.
// ----------------------------------------------------------------------------
module chbd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [chbd_pkg::SIZE_BITS-1:0]       cfg_wr_data,
  input  logic                                 tok_valid,
  input  chbd_pkg::tok_t                       tok,
  output logic                                 tok_take,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output chbd_pkg::res_t                       res
);

  localparam int SB = chbd_pkg::SIZE_BITS;
  localparam logic [SB-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_CRLF,
    PH_TRAIL,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    SUB_LEAD,
    SUB_DIGITS,
    SUB_TRAIL,
    SUB_EXT
  } sub_t;

  phase_t         phase_r, phase_nxt;
  sub_t           sub_r, sub_nxt;
  logic [SB-1:0]  acc_r, acc_nxt;
  logic           digit_r, digit_nxt;
  logic           cr_r, cr_nxt;
  logic [SB-1:0]  chunk_r, chunk_nxt;
  logic [SB-1:0]  pcnt_r, pcnt_nxt;
  logic           lim_flag_r, lim_flag_nxt;
  logic           tnz_r, tnz_nxt;
  logic [SB-1:0]  limit_r;
  logic [1:0]     cls;

  chbd_pkg::res_t q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           res_full;
  logic           pop;
  chbd_pkg::res_t res_new;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign res       = q_r[rd_ptr_r];
  assign tok_take  = tok_valid && !res_full;
  assign pop       = out_pop && !out_empty;

  always_comb begin
    phase_nxt    = phase_r;
    sub_nxt      = sub_r;
    acc_nxt      = acc_r;
    digit_nxt    = digit_r;
    cr_nxt       = cr_r;
    chunk_nxt    = chunk_r;
    pcnt_nxt     = pcnt_r;
    lim_flag_nxt = lim_flag_r;
    tnz_nxt      = tnz_r;
    cls          = chbd_pkg::CLS_FRAME;

    unique case (phase_r)
      PH_SIZE: begin
        if (tok.kind == chbd_pkg::TK_LF) begin
          if (!cr_r || !digit_r) begin
            phase_nxt = PH_ERR;
          end else begin
            chunk_nxt = acc_r;
            phase_nxt = (acc_r == '0) ? PH_TRAIL : PH_DATA;
            sub_nxt   = SUB_LEAD;
            acc_nxt   = '0;
            digit_nxt = 1'b0;
            cr_nxt    = 1'b0;
            tnz_nxt   = 1'b0;
          end
        end else begin
          cr_nxt = (tok.kind == chbd_pkg::TK_CR);
          if (sub_r == SUB_EXT) begin
            // Extension bytes are skipped up to the line end.
          end else if (cr_r) begin
            phase_nxt = PH_ERR;
          end else if (tok.kind == chbd_pkg::TK_CR) begin
            // Wait for the LF.
          end else if (tok.kind == chbd_pkg::TK_SEMI) begin
            sub_nxt = SUB_EXT;
          end else if (tok.kind == chbd_pkg::TK_WS) begin
            if (sub_r == SUB_DIGITS) sub_nxt = SUB_TRAIL;
          end else if (tok.kind != chbd_pkg::TK_HEX || sub_r == SUB_TRAIL) begin
            phase_nxt = PH_ERR;
          end else if (acc_r[SB-1:SB-4] != 4'd0) begin
            // Another digit would not fit in the size register.
            phase_nxt = PH_ERR;
          end else begin
            acc_nxt   = {acc_r[SB-5:0], tok.hex};
            digit_nxt = 1'b1;
            sub_nxt   = SUB_DIGITS;
          end
        end
      end
      PH_DATA: begin
        cls = chbd_pkg::CLS_PAYLOAD;
        if (pcnt_r != CNT_MAX) pcnt_nxt = pcnt_r + SB'(1);
        // The incremented count exceeds the limit exactly when the old count
        // reaches it, except when both sit at the saturation value.
        if (limit_r != '0 && pcnt_r >= limit_r &&
            !(pcnt_r == CNT_MAX && limit_r == CNT_MAX)) begin
          lim_flag_nxt = 1'b1;
        end
        if (chunk_r != '0) chunk_nxt = chunk_r - SB'(1);
        if (chunk_r <= SB'(1)) begin
          phase_nxt = PH_CRLF;
          cr_nxt    = 1'b0;
        end
      end
      PH_CRLF: begin
        if (tok.kind == chbd_pkg::TK_LF) begin
          phase_nxt = PH_SIZE;
          sub_nxt   = SUB_LEAD;
          acc_nxt   = '0;
          digit_nxt = 1'b0;
          cr_nxt    = 1'b0;
        end else if (tok.kind == chbd_pkg::TK_CR && !cr_r) begin
          cr_nxt = 1'b1;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_TRAIL: begin
        if (tok.kind == chbd_pkg::TK_LF && cr_r) begin
          cr_nxt = 1'b0;
          if (tnz_r) begin
            cls     = chbd_pkg::CLS_TRAILER;
            tnz_nxt = 1'b0;
          end else begin
            phase_nxt = PH_DONE;
          end
        end else if (tok.kind == chbd_pkg::TK_CR && !tnz_r && !cr_r) begin
          cr_nxt = 1'b1;
        end else begin
          tnz_nxt = 1'b1;
          cr_nxt  = (tok.kind == chbd_pkg::TK_CR);
          cls     = chbd_pkg::CLS_TRAILER;
        end
      end
      PH_DONE, PH_ERR: begin
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase

    res_new.byte_class   = cls;
    res_new.out_byte     = (cls != chbd_pkg::CLS_FRAME) ? tok.data : 8'd0;
    res_new.body_done    = (phase_nxt == PH_DONE);
    res_new.format_error = (phase_nxt == PH_ERR);
    res_new.over_limit   = lim_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIZE;
      sub_r      <= SUB_LEAD;
      acc_r      <= '0;
      digit_r    <= 1'b0;
      cr_r       <= 1'b0;
      chunk_r    <= '0;
      pcnt_r     <= '0;
      lim_flag_r <= 1'b0;
      tnz_r      <= 1'b0;
      limit_r    <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (tok_take) begin
        phase_r    <= phase_nxt;
        sub_r      <= sub_nxt;
        acc_r      <= acc_nxt;
        digit_r    <= digit_nxt;
        cr_r       <= cr_nxt;
        chunk_r    <= chunk_nxt;
        pcnt_r     <= pcnt_nxt;
        lim_flag_r <= lim_flag_nxt;
        tnz_r      <= tnz_nxt;
        wr_ptr_r   <= !wr_ptr_r;
      end
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(tok_take) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take) begin
      q_r[wr_ptr_r] <= res_new;
    end
  end

endmodule

/* rtl/core/http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// HTTP/1.1 chunked body decoder
// Decodes a chunked message body one byte per transaction and reports the
// class of each byte together with sticky done, error and over-limit flags.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock while in_full is low and gives one
// result per byte, in order. An accepted byte is classified into a two-entry
// token queue; the framing state machine then takes the token, updates its
// state and writes its result into a two-entry output queue, from which the
// result is shown on the out_ ports until it is popped. Sustained rate is one
// byte per cycle as long as results are popped; when they are not, the output
// queue fills, then the token queue, and in_full rises. body_limit is written
// through cfg_wr_en and cfg_wr_data; the user must change it only while the
// decoder has no byte in flight, as the block itself does not enforce this.
module http_chunked_body_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [chbd_pkg::SIZE_BITS-1:0]  cfg_wr_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_byte_class,
  output logic [7:0]                      out_out_byte,
  output logic                            out_body_done,
  output logic                            out_format_error,
  output logic                            out_over_limit
);

  logic           tok_valid;
  logic           tok_take;
  chbd_pkg::tok_t tok;
  chbd_pkg::res_t res;

  chbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_take     (tok_take)
  );

  chbd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tok_valid   (tok_valid),
    .tok         (tok),
    .tok_take    (tok_take),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .res         (res)
  );

  assign out_byte_class   = res.byte_class;
  assign out_out_byte     = res.out_byte;
  assign out_body_done    = res.body_done;
  assign out_format_error = res.format_error;
  assign out_over_limit   = res.over_limit;

endmodule

/* dv/tb_http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Streams a chunked body through the decoder with random gaps on both
// queues. A short table of directed bytes opens the run, random chunks with
// decorated size lines follow, and the run closes with a trailer section or
// one malformed line. Results are compared with a cycle-free framing model
// or with a typed table row; body_limit is rewritten between chunks.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;

  localparam int SB             = chbd_pkg::SIZE_BITS;
  localparam int RANDOM_BYTES   = 600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum logic [2:0] {
    ST_SIZE, ST_DATA, ST_CRLF, ST_TRAIL, ST_DONE, ST_ERR
  } body_state_t;

  typedef enum logic [1:0] {
    SL_LEAD, SL_DIGITS, SL_TRAIL, SL_EXT
  } size_part_t;

  typedef enum int {
    END_TRAILERS, END_BAD_CHAR, END_SPLIT_DIGITS, END_LONE_CR,
    END_BARE_LF, END_NO_DIGITS, END_OVERFLOW, END_NO_CHUNK_END
  } ending_t;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0]     data;
    bit             typed;
    chbd_pkg::res_t res;
  } row_t;

  logic          clk              = 1'b0;
  logic          rst_n            = 1'b0;
  logic          cfg_wr_en        = 1'b0;
  logic [SB-1:0] cfg_wr_data      = '0;
  logic          in_push          = 1'b0;
  logic          in_full;
  logic [7:0]    in_data_byte     = 8'h00;
  logic          out_empty;
  logic          out_pop          = 1'b0;
  logic [1:0]    out_byte_class;
  logic [7:0]    out_out_byte;
  logic          out_body_done;
  logic          out_format_error;
  logic          out_over_limit;

  http_chunked_body_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte_class   (out_byte_class),
    .out_out_byte     (out_out_byte),
    .out_body_done    (out_body_done),
    .out_format_error (out_format_error),
    .out_over_limit   (out_over_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder model state, at its reset values.
  body_state_t   ph             = ST_SIZE;
  size_part_t    part           = SL_LEAD;
  logic [SB-1:0] size_acc       = '0;
  logic          digit_seen     = 1'b0;
  logic          cr_pend        = 1'b0;
  logic [SB-1:0] chunk_left     = '0;
  logic [SB-1:0] payload_cnt    = '0;
  logic          over_flag      = 1'b0;
  logic          trail_nonempty = 1'b0;
  logic [SB-1:0] limit_val      = '0;

  chbd_pkg::res_t expected_byte_results[$];
  row_t           directed_rows[$];
  int     bytes_sent    = 0;
  int     limit_writes  = 0;
  int     mismatches    = 0;
  int     idle_cycles   = 0;
  int     pop_hold      = 0;
  bit     no_gaps       = 1'b0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void clear_size_line();
    part       = SL_LEAD;
    size_acc   = '0;
    digit_seen = 1'b0;
    cr_pend    = 1'b0;
  endfunction

  function automatic chbd_pkg::res_t decode_byte(input logic [7:0] c);
    chbd_pkg::res_t r;
    logic [1:0]     cls;
    logic           was_cr;
    int             d;
    cls = chbd_pkg::CLS_FRAME;
    case (ph)
      ST_SIZE: begin
        was_cr = cr_pend;
        if (c == chbd_pkg::CHAR_LF) begin
          if (!was_cr || !digit_seen) begin
            ph = ST_ERR;
          end else begin
            chunk_left = size_acc;
            ph = (size_acc == '0) ? ST_TRAIL : ST_DATA;
            clear_size_line();
            trail_nonempty = 1'b0;
          end
        end else begin
          cr_pend = (c == chbd_pkg::CHAR_CR);
          // Everything after the semicolon is skipped up to the line end.
          if (part != SL_EXT) begin
            if (was_cr) begin
              ph = ST_ERR;
            end else if (c == chbd_pkg::CHAR_CR) begin
              cr_pend = 1'b1;
            end else if (c == chbd_pkg::CHAR_SEMI) begin
              part = SL_EXT;
            end else if (c == chbd_pkg::CHAR_SP || c == chbd_pkg::CHAR_TAB) begin
              if (part == SL_DIGITS) part = SL_TRAIL;
            end else begin
              d = hex_value(c);
              if (d < 0 || part == SL_TRAIL || size_acc[SB-1 -: 4] != 4'd0) begin
                ph = ST_ERR;
              end else begin
                size_acc   = {size_acc[SB-5:0], 4'(d)};
                digit_seen = 1'b1;
                part       = SL_DIGITS;
              end
            end
          end
        end
      end
      ST_DATA: begin
        cls = chbd_pkg::CLS_PAYLOAD;
        if (payload_cnt != '1) payload_cnt = payload_cnt + SB'(1);
        if (limit_val != '0 && payload_cnt > limit_val) over_flag = 1'b1;
        if (chunk_left != '0) chunk_left = chunk_left - SB'(1);
        if (chunk_left == '0) begin
          ph      = ST_CRLF;
          cr_pend = 1'b0;
        end
      end
      ST_CRLF: begin
        if (c == chbd_pkg::CHAR_LF) begin
          ph = ST_SIZE;
          clear_size_line();
        end else if (c == chbd_pkg::CHAR_CR && !cr_pend) begin
          cr_pend = 1'b1;
        end else begin
          ph = ST_ERR;
        end
      end
      ST_TRAIL: begin
        if (c == chbd_pkg::CHAR_LF && cr_pend) begin
          cr_pend = 1'b0;
          if (trail_nonempty) begin
            cls            = chbd_pkg::CLS_TRAILER;
            trail_nonempty = 1'b0;
          end else begin
            ph = ST_DONE;
          end
        end else if (c == chbd_pkg::CHAR_CR && !trail_nonempty && !cr_pend) begin
          // A CR opening a trailer line is held back, not echoed.
          cr_pend = 1'b1;
        end else begin
          trail_nonempty = 1'b1;
          cr_pend        = (c == chbd_pkg::CHAR_CR);
          cls            = chbd_pkg::CLS_TRAILER;
        end
      end
      default: begin
      end
    endcase
    r.byte_class   = cls;
    r.out_byte     = (cls != chbd_pkg::CLS_FRAME) ? c : 8'h00;
    r.body_done    = (ph == ST_DONE);
    r.format_error = (ph == ST_ERR);
    r.over_limit   = over_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] white_char();
    return $urandom_range(0, 1) ? chbd_pkg::CHAR_SP : chbd_pkg::CHAR_TAB;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed,
                                  input logic [1:0] cls);
    row_t row;
    row.data             = b;
    row.typed            = typed;
    row.res.byte_class   = cls;
    row.res.out_byte     = (cls == chbd_pkg::CLS_FRAME) ? 8'h00 : b;
    row.res.body_done    = 1'b0;
    row.res.format_error = 1'b0;
    row.res.over_limit   = 1'b0;
    directed_rows = {directed_rows, row};
  endfunction

  // One transaction on the input queue; push stays high when no gap follows.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input chbd_pkg::res_t typed_res = '0);
    int             gap;
    chbd_pkg::res_t exp;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_full);
    exp = decode_byte(b);
    if (typed) exp = typed_res;
    expected_byte_results = {expected_byte_results, exp};
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic update_limit();
    logic [SB-1:0] v;
    if (limit_writes == 0) begin
      v = '1;
    end else if (limit_writes == 1) begin
      v = '0;
    end else if (limit_writes == 2) begin
      v = SB'({$urandom, $urandom});
    end else if (limit_writes == 3) begin
      // Lands a little past the current count so the flag trips mid-stream.
      v = payload_cnt + SB'($urandom_range(5, 60));
    end else if (limit_writes == 4) begin
      v = SB'(1);
    end else begin
      case ($urandom_range(0, 3))
        0: v = '1;
        1: v = '0;
        2: v = payload_cnt + SB'($urandom_range(0, 40));
        default: v = SB'({$urandom, $urandom});
      endcase
    end
    in_push <= 1'b0;
    while (expected_byte_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_val = v;
    limit_writes++;
  endtask

  task automatic send_chunk();
    byte_q_t       line;
    int            sz;
    int            top;
    logic [SB-1:0] size;
    sz = $urandom_range(0, 99);
    if (sz < 70) sz = $urandom_range(1, 16);
    else if (sz < 95) sz = $urandom_range(17, 64);
    else sz = $urandom_range(65, 200);
    size = SB'(sz);
    repeat ($urandom_range(0, 2)) line = {line, white_char()};
    // Runs of leading zeros keep the accumulator at zero.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 14)) line = {line, 8'h30};
    end
    top = 0;
    for (int i = 0; i < SB / 4; i++) begin
      if (size[i*4 +: 4] != 4'd0) top = i;
    end
    for (int i = top; i >= 0; i--) line = {line, hex_char(size[i*4 +: 4])};
    repeat ($urandom_range(0, 2)) line = {line, white_char()};
    if ($urandom_range(0, 3) == 0) begin
      line = {line, chbd_pkg::CHAR_SEMI};
      repeat ($urandom_range(0, 6)) begin
        logic [7:0] b;
        do b = 8'($urandom); while (b == chbd_pkg::CHAR_LF);
        line = {line, b};
      end
    end
    line = {line, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
    repeat (sz) line = {line, 8'($urandom)};
    if ($urandom_range(0, 4) != 0) line = {line, chbd_pkg::CHAR_CR};
    line = {line, chbd_pkg::CHAR_LF};
    send_bytes(line);
  endtask

  // Closes the body: a trailer section, or one malformed line that makes the
  // error sticky. Bytes after that must all come back as framing.
  task automatic send_ending();
    byte_q_t    line;
    int         pick;
    ending_t    how;
    logic [7:0] b;
    pick = $urandom_range(0, 13);
    how  = (pick < 7) ? END_TRAILERS : ending_t'(pick - 6);
    case (how)
      END_TRAILERS: begin
        line = {line, 8'h30};
        if ($urandom_range(0, 1)) begin
          line = {line, chbd_pkg::CHAR_SEMI, 8'h78};
        end
        line = {line, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 2) == 0) begin
            line = {line, chbd_pkg::CHAR_CR, 8'($urandom_range(8'h21, 8'h7E))};
          end
          repeat ($urandom_range(1, 12)) begin
            do b = 8'($urandom); while (b == chbd_pkg::CHAR_CR);
            line = {line, b};
          end
          line = {line, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
        end
        line = {line, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
      end
      END_BAD_CHAR: begin
        line = {line, 8'h31, 8'h67};
      end
      END_SPLIT_DIGITS: begin
        line = {line, 8'h31, white_char(), 8'h32};
        line = {line, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
      end
      END_LONE_CR: begin
        line = {line, 8'h31, chbd_pkg::CHAR_CR, 8'h58};
      end
      END_BARE_LF: begin
        line = {line, 8'h31, chbd_pkg::CHAR_LF};
      end
      END_NO_DIGITS: begin
        line = {line, white_char(), chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
      end
      END_OVERFLOW: begin
        line = {line, hex_char(4'($urandom_range(1, 15)))};
        repeat (SB / 4) line = {line, hex_char(4'($urandom))};
      end
      default: begin
        line = {line, 8'h32, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_LF};
        line = {line, 8'($urandom), 8'($urandom)};
        if ($urandom_range(0, 1)) begin
          line = {line, 8'h58};
        end else begin
          line = {line, chbd_pkg::CHAR_CR, chbd_pkg::CHAR_CR};
        end
      end
    endcase
    repeat ($urandom_range(10, 30)) line = {line, 8'($urandom)};
    send_bytes(line);
  endtask

  always @(posedge clk) begin
    if (pop_hold != 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop  <= 1'b1;
      pop_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_byte_results.size() == 0) begin
        $error("result transaction with no byte outstanding");
        mismatches++;
      end else begin
        chbd_pkg::res_t exp;
        exp = expected_byte_results.pop_front();
        if (out_byte_class !== exp.byte_class) begin
          $error("byte_class: expected %0d, actual %0d", exp.byte_class, out_byte_class);
          mismatches++;
        end
        if (out_out_byte !== exp.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", exp.out_byte, out_out_byte);
          mismatches++;
        end
        if (out_body_done !== exp.body_done) begin
          $error("body_done: expected %0b, actual %0b", exp.body_done, out_body_done);
          mismatches++;
        end
        if (out_format_error !== exp.format_error) begin
          $error("format_error: expected %0b, actual %0b",
                 exp.format_error, out_format_error);
          mismatches++;
        end
        if (out_over_limit !== exp.over_limit) begin
          $error("over_limit: expected %0b, actual %0b", exp.over_limit, out_over_limit);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int chunk_count;
    int directed_total;
    chunk_count = 0;

    // Size line with whitespace, a leading zero and an extension holding a CR.
    add_row(chbd_pkg::CHAR_SP,   1'b1, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_TAB,  1'b1, chbd_pkg::CLS_FRAME);
    add_row(8'h30,               1'b1, chbd_pkg::CLS_FRAME);
    add_row(8'h32,               1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_SP,   1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_SEMI, 1'b0, chbd_pkg::CLS_FRAME);
    add_row(8'h6B,               1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_CR,   1'b0, chbd_pkg::CLS_FRAME);
    add_row(8'h71,               1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_CR,   1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_LF,   1'b0, chbd_pkg::CLS_FRAME);
    // Payload extremes, then a bare LF as chunk end.
    add_row(8'h00,               1'b1, chbd_pkg::CLS_PAYLOAD);
    add_row(8'hFF,               1'b1, chbd_pkg::CLS_PAYLOAD);
    add_row(chbd_pkg::CHAR_LF,   1'b1, chbd_pkg::CLS_FRAME);
    // One-byte chunk whose payload is a CR.
    add_row(8'h31,               1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_CR,   1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_LF,   1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_CR,   1'b1, chbd_pkg::CLS_PAYLOAD);
    add_row(chbd_pkg::CHAR_CR,   1'b0, chbd_pkg::CLS_FRAME);
    add_row(chbd_pkg::CHAR_LF,   1'b0, chbd_pkg::CLS_FRAME);
    directed_total = directed_rows.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    update_limit();

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].res);
    end

    while (bytes_sent < directed_total + RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      if (chunk_count % 6 == 5) update_limit();
      send_chunk();
      chunk_count++;
    end
    no_gaps = 1'b0;
    send_ending();
    in_push <= 1'b0;

    while (expected_byte_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* http_chunked_body_decoder.f */
rtl/core/chbd_pkg.sv
rtl/core/chbd_front.sv
rtl/core/chbd_back.sv
rtl/core/http_chunked_body_decoder.sv
dv/tb_http_chunked_body_decoder.sv
